// ===== hw/rtl/unit_disk_point_sampler_defines.svh =====
// Assertion macros shared by the point sampler RTL.
`ifndef UNIT_DISK_POINT_SAMPLER_DEFINES_SVH
`define UNIT_DISK_POINT_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UDPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UDPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/udps_pkg.sv =====
// Types, constants and the elaboration-time rank table for the point sampler.
package udps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int RANK_W     = 7;
    localparam int TAKE_W     = 7;
    localparam int M_DATA_W   = 40;
    localparam int FRAC_DEN_LIMIT = 100;

    localparam logic [31:0]       LCG_MUL     = 32'd1103515245;
    localparam logic [31:0]       LCG_ADD     = 32'd12345;
    localparam logic [15:0]       COORD_SCALE = 16'd32767;
    localparam logic [29:0]       DISK_LIMIT  = 30'd1073676289;
    localparam logic [TAKE_W-1:0] TAKE_RESET  = 7'd16;

    localparam logic OP_SET_TAKE = 1'b0;
    localparam logic OP_RESEED   = 1'b1;

    typedef logic [MAX_POINTS-1:0][RANK_W-1:0] t_rank_tab;

    // Rank of each point index in the fraction-order table. Indices that are
    // never placed keep all ones, which no take count reaches.
    function automatic t_rank_tab build_rank_table(input int num_points);
        t_rank_tab              rank;
        logic [MAX_POINTS-1:0]  used;
        int                     fill;
        int                     d;
        int                     n;
        int                     k;
        int                     v;
        rank = '1;
        used = '0;
        rank[0] = '0;
        used[0] = 1'b1;
        rank[num_points-1] = RANK_W'(1);
        used[num_points-1] = 1'b1;
        fill = 2;
        for (d = 2; d < FRAC_DEN_LIMIT; d++) begin
            for (n = 1; n < d; n++) begin
                if (fill < num_points) begin
                    // Round n*N/d half up: largest k with 2*d*k <= 2*n*N + d.
                    v = 0;
                    for (k = 1; k <= num_points; k++) begin
                        if (2 * d * k <= 2 * n * num_points + d) begin
                            v = k;
                        end
                    end
                    if (v < num_points && !used[v]) begin
                        used[v] = 1'b1;
                        rank[v] = RANK_W'(fill);
                        fill++;
                    end
                end
            end
        end
        return rank;
    endfunction

endpackage

// ===== hw/rtl/unit_disk_point_sampler.sv =====
// Unit disk point sampler: LCG rejection sampling into a point store, ranked emit.
//
// Slave channel: one request per command. s_tuser carries the opcode and
// s_tdata the 32-bit value. Opcode 0 sets the take count (saturated to
// NUM_POINTS) and emits; opcode 1 seeds the generator, refills every stored
// point and then emits. Master channel: one result per selected point in
// ascending index order, tlast on the final one; a take of zero gives none.
// A single 32x32 multiplier, registered at its output, serves both the
// generator step and the squares of the coordinates. One candidate pair
// passes through MUL_A, ADD_A, MUL_B, ADD_B, SQ1, SQ2 and CMP (two generator
// steps, two squares, one compare); rejected pairs are retried, so a refill
// varies with the seed. The emit walk visits each unselected index in SCAN and
// takes each emitted point through SCAN, LOAD and WAIT; WAIT holds while
// m_tready is low. s_tready is high only while the block is idle, which it
// reaches in the cycle after the walk passes the top index. For a take of two
// or more that is the cycle after the last result is taken; for a take of one
// the walk first scans the remaining indices. A stalled receiver freezes the
// walk with the result held in the output register.
// Reset clears the generator state, sets the take count to 16 and marks all
// stored points invalid, so they read as zero until the first refill.
module unit_disk_point_sampler
    import udps_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,   // value
    input  logic                i_s_tuser,   // opcode
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // point_index, real_part, imag_part, zero pad
    output logic                o_m_tlast    // last
);

    `include "unit_disk_point_sampler_defines.svh"

    localparam int                IDX_W    = $clog2(NUM_POINTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_POINTS - 1);
    localparam t_rank_tab         RANK     = build_rank_table(NUM_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_ADD_A,
        ST_MUL_B,
        ST_ADD_B,
        ST_SQ1,
        ST_SQ2,
        ST_CMP,
        ST_SCAN,
        ST_LOAD,
        ST_WAIT
    } t_state;

    t_state                 r_state, n_state;
    logic [31:0]            r_lcg, n_lcg;
    logic [31:0]            r_prod, n_prod;
    logic [29:0]            r_acc, n_acc;
    logic signed [15:0]     r_c1, n_c1;
    logic signed [15:0]     r_c2, n_c2;
    logic [TAKE_W-1:0]      r_take, n_take;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [NUM_POINTS-1:0]  r_valid, n_valid;
    logic                   r_m_tvalid, n_m_tvalid;
    logic [M_DATA_W-1:0]    r_m_tdata, n_m_tdata;
    logic                   r_m_tlast, n_m_tlast;

    logic [31:0]            r_mem [NUM_POINTS];
    logic [31:0]            r_rdata;
    logic                   r_rd_valid;

    logic [31:0]            w_mul_a, w_mul_b;
    logic [31:0]            w_mul_full;
    logic signed [15:0]     w_coord;
    logic [14:0]            w_abs1, w_abs2;
    logic [30:0]            w_sum;
    logic                   w_inside;
    logic                   w_sel;
    logic                   w_wr;
    logic [IDX_W-1:0]       w_last_idx;
    logic [31:0]            w_point;

    // Coordinate 2r - 32767 from bits 30..16 of the current generator state.
    assign w_coord = signed'({r_lcg[30:16], 1'b0} - COORD_SCALE);

    assign w_abs1 = r_c1[15] ? 15'(-r_c1) : r_c1[14:0];
    assign w_abs2 = r_c2[15] ? 15'(-r_c2) : r_c2[14:0];

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = r_lcg;
        w_mul_b = LCG_MUL;
        case (r_state)
            ST_SQ1: begin
                w_mul_a = 32'(w_abs1);
                w_mul_b = 32'(w_abs1);
            end
            ST_SQ2: begin
                w_mul_a = 32'(w_abs2);
                w_mul_b = 32'(w_abs2);
            end
            default: begin
                w_mul_a = r_lcg;
                w_mul_b = LCG_MUL;
            end
        endcase
    end

    // Only the low word is needed: the generator works modulo 2^32 and a
    // square of a 15-bit magnitude fits in 30 bits.
    assign w_mul_full = w_mul_a * w_mul_b;

    assign w_sum    = {1'b0, r_acc} + {1'b0, r_prod[29:0]};
    assign w_inside = (w_sum <= {1'b0, DISK_LIMIT});
    assign w_wr     = (r_state == ST_CMP) && w_inside;

    assign w_sel = (RANK[r_idx] < r_take);

    // Entry 1 of the order table is the top index, so any take of two or more
    // ends on it; a take of one selects only index zero.
    assign w_last_idx = (r_take >= TAKE_W'(2)) ? LAST_IDX : '0;

    assign w_point = r_rd_valid ? r_rdata : '0;

    // Sequencer next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_lcg      = r_lcg;
        n_prod     = r_prod;
        n_acc      = r_acc;
        n_c1       = r_c1;
        n_c2       = r_c2;
        n_take     = r_take;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tlast  = r_m_tlast;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_idx = '0;
                    if (i_s_tuser == OP_RESEED) begin
                        n_lcg   = i_s_tdata;
                        n_state = ST_MUL_A;
                    end else begin
                        n_take  = (i_s_tdata > 32'(NUM_POINTS)) ?
                                  TAKE_W'(NUM_POINTS) : i_s_tdata[TAKE_W-1:0];
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_MUL_A: begin
                n_prod  = w_mul_full;
                n_state = ST_ADD_A;
            end
            ST_ADD_A: begin
                n_lcg   = r_prod + LCG_ADD;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                n_c1    = w_coord;
                n_prod  = w_mul_full;
                n_state = ST_ADD_B;
            end
            ST_ADD_B: begin
                n_lcg   = r_prod + LCG_ADD;
                n_state = ST_SQ1;
            end
            ST_SQ1: begin
                n_c2    = w_coord;
                n_prod  = w_mul_full;
                n_state = ST_SQ2;
            end
            ST_SQ2: begin
                n_acc   = r_prod[29:0];
                n_prod  = w_mul_full;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!w_inside) begin
                    n_state = ST_MUL_A;
                end else begin
                    n_valid[r_idx] = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_MUL_A;
                    end
                end
            end
            ST_SCAN: begin
                if (w_sel) begin
                    n_state = ST_LOAD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LOAD: begin
                n_m_tvalid = 1'b1;
                n_m_tdata  = {2'b00, w_point[15:0], w_point[31:16], 6'(r_idx)};
                n_m_tlast  = (r_idx == w_last_idx);
                n_state    = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_m_tready) begin
                    n_m_tvalid = 1'b0;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lcg      <= '0;
            r_take     <= TAKE_RESET;
            r_idx      <= '0;
            r_valid    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_lcg      <= n_lcg;
            r_take     <= n_take;
            r_idx      <= n_idx;
            r_valid    <= n_valid;
            r_m_tvalid <= n_m_tvalid;
        end
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_c1      <= n_c1;
        r_c2      <= n_c2;
        r_m_tdata <= n_m_tdata;
        r_m_tlast <= n_m_tlast;
    end

    // Point store: imaginary coordinate low, real coordinate high.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_idx] <= {r_c2, r_c1};
        end
        if (r_state == ST_SCAN) begin
            r_rdata    <= r_mem[r_idx];
            r_rd_valid <= r_valid[r_idx];
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    // Checks on the sequencer and datapath.
    `UDPS_ASSERT_NOW(a_ready_excl_valid, i_clk, i_rst_n, o_s_tready, !o_m_tvalid,
                     "result pending while idle")
    `UDPS_ASSERT_NOW(a_coords_odd, i_clk, i_rst_n, r_state == ST_CMP,
                     r_c1[0] && r_c2[0], "even coordinate in compare")
    `UDPS_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
                     o_m_tdata[IDX_W-1:0] == w_last_idx, "tlast on wrong index")
    `UDPS_ASSERT_NEXT(a_request_starts, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
                      r_state == ST_MUL_A || r_state == ST_SCAN, "request did not start work")

endmodule

// ===== dv/point_stream_checker.sv =====
// Checker for the point sampler: predicts each request's result stream and compares it.
module point_stream_checker
    import udps_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [31:0]         i_s_tdata,   // value
    input  logic                i_s_tuser,   // opcode
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,   // point_index, real_part, imag_part, zero pad
    input  logic                i_m_tlast,   // last
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [31:0] GEN_MUL    = 32'd1103515245;
    localparam logic [31:0] GEN_ADD    = 32'd12345;
    localparam int          UNIT_SCALE = 32767;
    localparam int          TAKE_AFTER_RESET = 16;
    localparam int          DEN_LIMIT  = 100;

    typedef struct packed {
        logic [5:0]  index;
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } point_result_t;

    point_result_t expected_points[$];

    logic [31:0] gen_state;
    logic [6:0]  take_q;
    logic [15:0] c1_mem [NUM_POINTS];
    logic [15:0] c2_mem [NUM_POINTS];
    int          rank_of [NUM_POINTS];

    // Rank of every index in the fraction-order table; unplaced indices stay out of reach.
    function automatic void build_ranks();
        int fill;
        int v;
        for (int k = 0; k < NUM_POINTS; k++) begin
            rank_of[k] = 255;
        end
        rank_of[0] = 0;
        rank_of[NUM_POINTS-1] = 1;
        fill = 2;
        for (int d = 2; d < DEN_LIMIT; d++) begin
            for (int n = 1; n < d; n++) begin
                v = (2 * n * NUM_POINTS + d) / (2 * d);
                if (fill < NUM_POINTS && v < NUM_POINTS && rank_of[v] == 255) begin
                    rank_of[v] = fill;
                    fill++;
                end
            end
        end
    endfunction

    // One generator step; the draw is bits 30..16 of the new state.
    function automatic logic [14:0] next_draw();
        gen_state = gen_state * GEN_MUL + GEN_ADD;
        return gen_state[30:16];
    endfunction

    // Refill every stored point by rejection sampling inside the unit disk.
    function automatic void refill_points();
        int     c1;
        int     c2;
        longint bound;
        bound = longint'(UNIT_SCALE) * UNIT_SCALE;
        for (int i = 0; i < NUM_POINTS; i++) begin
            do begin
                c1 = 2 * int'(next_draw()) - UNIT_SCALE;
                c2 = 2 * int'(next_draw()) - UNIT_SCALE;
            end while (longint'(c1) * c1 + longint'(c2) * c2 > bound);
            c1_mem[i] = c1[15:0];
            c2_mem[i] = c2[15:0];
        end
    endfunction

    // Queue the emit walk: selected indices in ascending order, last one flagged.
    function automatic void queue_emit();
        int            last_idx;
        point_result_t res;
        last_idx = -1;
        for (int i = 0; i < NUM_POINTS; i++) begin
            if (rank_of[i] < int'(take_q)) begin
                last_idx = i;
            end
        end
        for (int i = 0; i < NUM_POINTS; i++) begin
            if (rank_of[i] < int'(take_q)) begin
                res.index = 6'(i);
                res.re    = c2_mem[i];
                res.im    = c1_mem[i];
                res.last  = (i == last_idx);
                expected_points.push_back(res);
            end
        end
    endfunction

    // Compare one delivered point against the oldest expectation, field by field.
    function automatic void check_point();
        point_result_t want;
        if (expected_points.size() == 0) begin
            $error("unexpected result: point_index %0d", i_m_tdata[5:0]);
            o_fail_count++;
        end else begin
            want = expected_points.pop_front();
            if (i_m_tdata[5:0] !== want.index) begin
                $error("point_index: expected %0d, got %0d", want.index, i_m_tdata[5:0]);
                o_fail_count++;
            end
            if (i_m_tdata[21:6] !== want.re) begin
                $error("real_part: expected %0d, got %0d",
                       $signed(want.re), $signed(i_m_tdata[21:6]));
                o_fail_count++;
            end
            if (i_m_tdata[37:22] !== want.im) begin
                $error("imag_part: expected %0d, got %0d",
                       $signed(want.im), $signed(i_m_tdata[37:22]));
                o_fail_count++;
            end
            if (i_m_tdata[M_DATA_W-1:38] !== '0) begin
                $error("pad: expected 0, got %0h", i_m_tdata[M_DATA_W-1:38]);
                o_fail_count++;
            end
            if (i_m_tlast !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, i_m_tlast);
                o_fail_count++;
            end
        end
    endfunction

    function automatic void clear_model();
        gen_state = '0;
        take_q    = 7'(TAKE_AFTER_RESET);
        for (int i = 0; i < NUM_POINTS; i++) begin
            c1_mem[i] = '0;
            c2_mem[i] = '0;
        end
        expected_points.delete();
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        build_ranks();
        clear_model();
    end

    // Both channels are sampled at the rising edge; a request is predicted before any result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_SET_TAKE) begin
                    take_q = (i_s_tdata > NUM_POINTS) ? 7'(NUM_POINTS) : 7'(i_s_tdata);
                end else begin
                    gen_state = i_s_tdata;
                    refill_points();
                end
                queue_emit();
            end
            if (i_m_tvalid && i_m_tready) begin
                check_point();
            end
        end
        o_pending = expected_points.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the point sampler: clock, reset, request stimulus, stalls and verdict.
module tb;
    import udps_pkg::*;

    localparam int NUM_POINTS  = 64;
    localparam int RANDOM_REQS = 250;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_LONG
    } stall_mode_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [31:0]         i_s_tdata;   // value
    logic                i_s_tuser;   // opcode
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;   // point_index, real_part, imag_part, zero pad
    logic                o_m_tlast;   // last

    int fail_count;
    int pending;
    int burst_left;

    unit_disk_point_sampler #(
        .NUM_POINTS (NUM_POINTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    point_stream_checker #(
        .NUM_POINTS (NUM_POINTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #24_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver stalls: modes of random length, from always ready to long holds.
    initial begin
        stall_mode_t mode;
        int          span;
        mode = STALL_NONE;
        span = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = stall_mode_t'($urandom_range(0, 3));
                span = (mode == STALL_LONG) ? $urandom_range(5, 40) : $urandom_range(20, 200);
            end
            span--;
            case (mode)
                STALL_NONE:  i_m_tready = 1'b1;
                STALL_HALF:  i_m_tready = 1'($urandom_range(0, 1));
                STALL_HEAVY: i_m_tready = ($urandom_range(0, 3) == 0);
                default:     i_m_tready = 1'b0;
            endcase
        end
    end

    // Present one request and hold it until accepted; gaps fall between bursts.
    task automatic send_request(input logic op, input logic [31:0] val);
        int gap;
        i_s_tuser  = op;
        i_s_tdata  = val;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(100, 1200);
                default: gap = $urandom_range(1, 10);
            endcase
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                i_s_tuser  = 1'($urandom_range(0, 1));
                i_s_tdata  = $urandom;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Mostly take counts from zero to the top, some just past the top and some anywhere in 32 bits.
    function automatic logic [31:0] pick_take();
        case ($urandom_range(0, 9))
            6:       return 32'(NUM_POINTS);
            7:       return $urandom_range(NUM_POINTS + 1, 300);
            8, 9:    return $urandom;
            default: return $urandom_range(0, NUM_POINTS);
        endcase
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_SET_TAKE;
        burst_left = 1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Points still read zero from reset; take counts at and around the extremes.
        send_request(OP_SET_TAKE, 32'd16);
        send_request(OP_SET_TAKE, 32'd0);
        send_request(OP_SET_TAKE, 32'd1);
        send_request(OP_SET_TAKE, 32'd64);
        send_request(OP_SET_TAKE, 32'd65);
        send_request(OP_SET_TAKE, 32'hFFFF_FFFF);
        // Reseeds at the seed extremes, then takes around the full table.
        send_request(OP_RESEED,   32'h0000_0000);
        send_request(OP_RESEED,   32'hFFFF_FFFF);
        send_request(OP_SET_TAKE, 32'd63);
        send_request(OP_SET_TAKE, 32'd2);
        send_request(OP_RESEED,   32'h8000_0000);
        // A reseed with a take of zero refills silently.
        send_request(OP_SET_TAKE, 32'd0);
        send_request(OP_RESEED,   32'h1234_5678);
        send_request(OP_SET_TAKE, 32'h8000_0040);
        send_request(OP_SET_TAKE, 32'd7);
        send_request(OP_RESEED,   32'hAAAA_AAAA);
        send_request(OP_RESEED,   32'h5555_5555);
        send_request(OP_SET_TAKE, 32'd16);
        send_request(OP_SET_TAKE, 32'd100);

        // Random mix of reseeds and take changes.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                send_request(OP_RESEED, $urandom);
            end else begin
                send_request(OP_SET_TAKE, pick_take());
            end
        end
        i_s_tvalid = 1'b0;

        // Drain every outstanding point, then watch for strays.
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
